// ===== rtl/tvhm_pkg.sv =====
// shared constants, codes, vocabulary clamp and slot geometry helpers for the token vocabulary map
// no dependencies; imported by the top level
`default_nettype none

package tvhm_pkg;

    localparam int VOCAB_MAX     = 32768;
    localparam int TABLE_SLOTS   = 65536;
    localparam int MAX_PIECE_LEN = 64;

    localparam int ID_W   = 15;
    localparam int SLOT_W = 16;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int BADR_W = ID_W + IDX_W;
    localparam int CFG_W  = 16;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ID_RANGE  = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // clamp the vocabulary size to the id space
    function automatic logic [CFG_W-1:0] eff_vocab(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] e;
        e = (v > CFG_W'(VOCAB_MAX)) ? CFG_W'(VOCAB_MAX) : v;
        return e;
    endfunction

    // slot mask: next power of two of twice the vocabulary, minus one
    function automatic logic [SLOT_W-1:0] slot_mask(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] e;
        logic [CFG_W:0]   w;
        logic [SLOT_W-1:0] m;
        e = eff_vocab(v);
        w = {e, 1'b0} - (CFG_W+1)'(1);
        m = w[SLOT_W-1:0];
        for (int k = 1; k < SLOT_W; k = k * 2) begin
            m = m | (m >> k);
        end
        if (e == '0) begin
            m = '0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tvhm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tvhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/token_vocab_hash_map_unit.sv =====
// token vocabulary map: fnv-1a hash of piece bytes, linear-probing slot table,
// per-id piece storage; depends on tvhm_pkg and tvhm_ram
//
// Usage:
//   input channel (in_valid / in_stall) takes one word per piece byte; the word
//   with byte_last set carries req_type and tok_id and ends the request.
//   Non-final words are taken one per cycle. After the final word the block
//   holds in_stall high while it probes and compares, then drives results on
//   the output channel (out_valid / out_stall). Insert and lookup give one
//   word, a read by id gives one word per stored byte (or one empty word).
//   After the final word the block reads and checks each probed slot; a lookup
//   also reads the length of each occupied slot it checks and compares the
//   bytes, an insert copies each byte; a rejected request goes straight to its
//   result word; a read reads the stored length, then reads and sends each
//   byte in turn, waiting while the receiver stalls.
//   The table walk runs over the slot and piece memories, each with one read and
//   one write port. A finished result sits in the output register, so the next
//   request is taken while it waits; a stalled receiver holds that word.
//   After reset and after every vocabulary size write the block sweeps the
//   slot and length memories with in_stall high.
`default_nettype none

module token_vocab_hash_map_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [tvhm_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 req_type,
    input  wire logic [tvhm_pkg::ID_W-1:0]  tok_id,
    input  wire logic [7:0]                 piece_byte,
    input  wire logic                       has_byte,
    input  wire logic                       byte_last,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [2:0]                      status,
    output logic [tvhm_pkg::ID_W-1:0]       found_id,
    output logic [tvhm_pkg::LEN_W-1:0]      stored_length,
    output logic [7:0]                      out_byte,
    output logic                            out_byte_valid,
    output logic                            last_of_run
);

    import tvhm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_PROBE_RD, S_PROBE_CHK, S_LEN_CHK,
        S_CMP_RD, S_CMP_CHK, S_COPY_RD, S_COPY_WR, S_RLEN, S_READ_RD,
        S_READ_OUT, S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W:0]     clr_reg, clr_next;
    logic [SLOT_W-1:0]   mask_reg, mask_next;
    logic [CFG_W-1:0]    eff_reg, eff_next;
    logic [31:0]         hash_reg, hash_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]         hlat_reg, hlat_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [1:0]          req_reg, req_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic [SLOT_W:0]     n_reg, n_next;
    logic [ID_W-1:0]     cand_reg, cand_next;
    logic [LEN_W-1:0]    i_reg, i_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    status_t             res_st_reg, res_st_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;

    logic                ov_reg, ov_next;
    logic [2:0]          ost_reg, ost_next;
    logic [ID_W-1:0]     oid_reg, oid_next;
    logic [LEN_W-1:0]    olen_reg, olen_next;
    logic [7:0]          ob_reg, ob_next;
    logic                obv_reg, obv_next;
    logic                olast_reg, olast_next;

    // memory ports
    logic                slot_we, slot_re;
    logic [SLOT_W-1:0]   slot_waddr, slot_raddr, slot_wdata, slot_rdata;
    logic                len_we, len_re;
    logic [ID_W-1:0]     len_waddr, len_raddr;
    logic [LEN_W-1:0]    len_wdata, len_rdata;
    logic                byte_we, byte_re;
    logic [BADR_W-1:0]   byte_waddr, byte_raddr;
    logic [7:0]          byte_wdata, byte_rdata;
    logic                inc_we, inc_re;
    logic [IDX_W-1:0]    inc_waddr, inc_raddr;
    logic [7:0]          inc_rdata;

    logic                can_load;
    logic                in_take;
    logic [31:0]         hash_mul;
    logic [LEN_W-1:0]    i_inc;

    tvhm_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
    );

    tvhm_ram #(.WIDTH(LEN_W), .DEPTH(VOCAB_MAX)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .re(len_re), .raddr(len_raddr), .rdata(len_rdata)
    );

    tvhm_ram #(.WIDTH(8), .DEPTH(VOCAB_MAX * MAX_PIECE_LEN)) u_byte_ram (
        .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
        .re(byte_re), .raddr(byte_raddr), .rdata(byte_rdata)
    );

    tvhm_ram #(.WIDTH(8), .DEPTH(MAX_PIECE_LEN)) u_inc_ram (
        .clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(piece_byte),
        .re(inc_re), .raddr(inc_raddr), .rdata(inc_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign can_load = !ov_reg || !out_stall;
    assign hash_mul = (hash_reg ^ {24'd0, piece_byte}) * FNV_PRIME;
    assign i_inc    = i_reg + LEN_W'(1);

    // next state and memory control
    always_comb
    begin
        logic adv;
        logic [SLOT_W-1:0] e;
        adv = 1'b0;
        e = slot_rdata;

        state_next  = state_reg;
        clr_next    = clr_reg;
        mask_next   = mask_reg;
        eff_next    = eff_reg;
        hash_next   = hash_reg;
        cnt_next    = cnt_reg;
        hlat_next   = hlat_reg;
        len_next    = len_reg;
        req_next    = req_reg;
        id_next     = id_reg;
        ptr_next    = ptr_reg;
        n_next      = n_reg;
        cand_next   = cand_reg;
        i_next      = i_reg;
        plen_next   = plen_reg;
        res_st_next = res_st_reg;
        res_id_next = res_id_reg;
        ov_next     = ov_reg && out_stall;
        ost_next    = ost_reg;
        oid_next    = oid_reg;
        olen_next   = olen_reg;
        ob_next     = ob_reg;
        obv_next    = obv_reg;
        olast_next  = olast_reg;

        slot_we = 1'b0; slot_waddr = ptr_reg; slot_wdata = '0;
        slot_re = 1'b0; slot_raddr = ptr_reg;
        len_we = 1'b0; len_waddr = id_reg; len_wdata = len_reg;
        len_re = 1'b0; len_raddr = id_reg;
        byte_we = 1'b0; byte_waddr = {id_reg, i_reg[IDX_W-1:0]}; byte_wdata = inc_rdata;
        byte_re = 1'b0; byte_raddr = {id_reg, i_reg[IDX_W-1:0]};
        inc_we = 1'b0; inc_waddr = cnt_reg[IDX_W-1:0];
        inc_re = 1'b0; inc_raddr = i_reg[IDX_W-1:0];

        case (state_reg)
            // sweep slot and length memories to empty
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg[SLOT_W-1:0];
                len_we     = (clr_reg < (SLOT_W+1)'(VOCAB_MAX));
                len_waddr  = clr_reg[ID_W-1:0];
                len_wdata  = '0;
                clr_next   = clr_reg + (SLOT_W+1)'(1);
                if (clr_reg == (SLOT_W+1)'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            // take piece bytes, fold into hash
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        hash_next = hash_mul;
                        if (cnt_reg < LEN_W'(MAX_PIECE_LEN))
                        begin
                            inc_we   = 1'b1;
                            cnt_next = cnt_reg + LEN_W'(1);
                        end
                        else
                        begin
                            cnt_next = LEN_W'(MAX_PIECE_LEN + 1);
                        end
                    end
                    if (byte_last)
                    begin
                        hlat_next  = has_byte ? hash_mul : hash_reg;
                        len_next   = cnt_next;
                        req_next   = req_type;
                        id_next    = tok_id;
                        hash_next  = FNV_BASIS;
                        cnt_next   = '0;
                        state_next = S_DISPATCH;
                    end
                end
            end
            // pick the operation
            S_DISPATCH:
            begin
                ptr_next    = hlat_reg[SLOT_W-1:0] & mask_reg;
                n_next      = '0;
                res_id_next = '0;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if ({1'b0, id_reg} >= eff_reg)
                        begin
                            res_st_next = ST_ID_RANGE;
                            state_next  = S_RESULT;
                        end
                        else if (len_reg > LEN_W'(MAX_PIECE_LEN))
                        begin
                            res_st_next = ST_TOO_LONG;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PROBE_RD;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (len_reg > LEN_W'(MAX_PIECE_LEN))
                        begin
                            res_st_next = ST_TOO_LONG;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PROBE_RD;
                        end
                    end
                    REQ_READ:
                    begin
                        if ({1'b0, id_reg} >= eff_reg)
                        begin
                            res_st_next = ST_ID_RANGE;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            len_re     = 1'b1;
                            state_next = S_RLEN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PROBE_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_PROBE_CHK;
            end
            // empty slot or candidate entry
            S_PROBE_CHK:
            begin
                if (e == '0)
                begin
                    if (req_reg == REQ_INSERT)
                    begin
                        slot_we     = 1'b1;
                        slot_wdata  = SLOT_W'({1'b0, id_reg} + (ID_W+1)'(1));
                        len_we      = 1'b1;
                        i_next      = '0;
                        res_st_next = ST_OK;
                        state_next  = (len_reg == '0) ? S_RESULT : S_COPY_RD;
                    end
                    else
                    begin
                        res_st_next = ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end
                end
                else if (req_reg == REQ_INSERT)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    cand_next  = ID_W'(e - SLOT_W'(1));
                    len_re     = 1'b1;
                    len_raddr  = ID_W'(e - SLOT_W'(1));
                    state_next = S_LEN_CHK;
                end
            end
            S_LEN_CHK:
            begin
                if (len_rdata == len_reg)
                begin
                    i_next = '0;
                    if (len_reg == '0)
                    begin
                        res_st_next = ST_OK;
                        res_id_next = cand_reg;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_CMP_RD;
                    end
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_CMP_RD:
            begin
                byte_re    = 1'b1;
                byte_raddr = {cand_reg, i_reg[IDX_W-1:0]};
                inc_re     = 1'b1;
                state_next = S_CMP_CHK;
            end
            // compare one stored byte against the incoming piece
            S_CMP_CHK:
            begin
                if (byte_rdata != inc_rdata)
                begin
                    adv = 1'b1;
                end
                else if (i_inc == len_reg)
                begin
                    res_st_next = ST_OK;
                    res_id_next = cand_reg;
                    state_next  = S_RESULT;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_CMP_RD;
                end
            end
            S_COPY_RD:
            begin
                inc_re     = 1'b1;
                state_next = S_COPY_WR;
            end
            // copy incoming piece into id storage
            S_COPY_WR:
            begin
                byte_we = 1'b1;
                i_next  = i_inc;
                state_next = (i_inc == len_reg) ? S_RESULT : S_COPY_RD;
            end
            S_RLEN:
            begin
                plen_next = len_rdata;
                i_next    = '0;
                if (len_rdata == '0)
                begin
                    res_st_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_READ_RD;
                end
            end
            S_READ_RD:
            begin
                byte_re    = 1'b1;
                state_next = S_READ_OUT;
            end
            // stream one stored byte
            S_READ_OUT:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    oid_next   = '0;
                    olen_next  = plen_reg;
                    ob_next    = byte_rdata;
                    obv_next   = 1'b1;
                    olast_next = (i_inc == plen_reg);
                    i_next     = i_inc;
                    state_next = (i_inc == plen_reg) ? S_IDLE : S_READ_RD;
                end
            end
            // single result word
            S_RESULT:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    oid_next   = res_id_reg;
                    olen_next  = '0;
                    ob_next    = '0;
                    obv_next   = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next slot or give up after a full round
        if (adv)
        begin
            if (n_reg == {1'b0, mask_reg})
            begin
                res_st_next = ST_FULL;
                res_id_next = '0;
                state_next  = S_RESULT;
            end
            else
            begin
                n_next     = n_reg + (SLOT_W+1)'(1);
                ptr_next   = (ptr_reg + SLOT_W'(1)) & mask_reg;
                state_next = S_PROBE_RD;
            end
        end

        // vocabulary write rebuilds the map
        if (cfg_we)
        begin
            eff_next   = eff_vocab(cfg_wdata);
            mask_next  = slot_mask(cfg_wdata);
            hash_next  = FNV_BASIS;
            cnt_next   = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // state, control registers and out_valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mask_reg  <= slot_mask(CFG_W'(VOCAB_MAX));
            eff_reg   <= CFG_W'(VOCAB_MAX);
            hash_reg  <= FNV_BASIS;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mask_reg  <= mask_next;
            eff_reg   <= eff_next;
            hash_reg  <= hash_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hlat_reg   <= hlat_next;
        len_reg    <= len_next;
        req_reg    <= req_next;
        id_reg     <= id_next;
        ptr_reg    <= ptr_next;
        n_reg      <= n_next;
        cand_reg   <= cand_next;
        i_reg      <= i_next;
        plen_reg   <= plen_next;
        res_st_reg <= res_st_next;
        res_id_reg <= res_id_next;
        ost_reg    <= ost_next;
        oid_reg    <= oid_next;
        olen_reg   <= olen_next;
        ob_reg     <= ob_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign status         = ost_reg;
    assign found_id       = oid_reg;
    assign stored_length  = olen_reg;
    assign out_byte       = ob_reg;
    assign out_byte_valid = obv_reg;
    assign last_of_run    = olast_reg;

    // checks
    a_slot_claim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_we && state_reg != S_CLEAR) |-> (slot_wdata != '0))
        else $error("claimed slot written as empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LEN_W'(MAX_PIECE_LEN + 1))
        else $error("incoming count past saturation");

    a_last_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && byte_last && !cfg_we) |=> (state_reg == S_DISPATCH))
        else $error("final word did not start dispatch");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_we |-> ({1'b0, id_reg} < eff_reg))
        else $error("piece stored under id out of range");

endmodule

`default_nettype wire
